// ----- sv/life_generation_engine_core_assert.svh -----
// ----------------------------------------------------------------------------
// Life generation engine assertion macros
// Concurrent check macros shared by the engine RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_ENGINE_CORE_ASSERT_SVH
`define LIFE_GENERATION_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LGE_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define LGE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define LGE_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define LGE_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ----- sv/lge_pkg.sv -----
// ----------------------------------------------------------------------------
// Life generation engine package
// Command codes, sequencer states, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package lge_pkg;

  localparam int CMD_W      = 2;
  localparam int COORD_W    = 6;
  localparam int SIZE_REG_W = 7;
  localparam int GEN_W      = 32;
  localparam int NBR_COUNT  = 8;
  localparam int NBR_CNT_W  = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [NBR_CNT_W-1:0]  BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_CNT_W-1:0]  SURVIVE_COUNT = 4'd2;
  localparam logic [SIZE_REG_W-1:0] SIZE_RESET    = 7'd64;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_NOP     = 2'd3
  } lge_cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_FETCH,
    ST_CAPTURE,
    ST_CELL,
    ST_WB,
    ST_SCAN,
    ST_OUT
  } lge_state_t;

  typedef struct packed {
    logic [NBR_COUNT-1:0] nbr;
    logic                 alive;
  } lge_nbhd_t;

endpackage

`default_nettype wire

// ----- sv/lge_if.sv -----
// ----------------------------------------------------------------------------
// Life generation engine channels
// Valid/ready command channel and result channel with source and sink views.
// ----------------------------------------------------------------------------
`default_nettype none

interface lge_in_if import lge_pkg::*; ();
  logic                 valid;
  logic                 ready;
  lge_cmd_t             command;
  logic [COORD_W-1:0]   col;
  logic [COORD_W-1:0]   row;
  logic                 cell_in;

  modport source (output valid, command, col, row, cell_in, input ready);
  modport sink   (input valid, command, col, row, cell_in, output ready);
endinterface

interface lge_out_if import lge_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cell_out;
  logic              border_alive;
  logic [GEN_W-1:0]  generation;

  modport source (output valid, cell_out, border_alive, generation, input ready);
  modport sink   (input valid, cell_out, border_alive, generation, output ready);
endinterface

`default_nettype wire

// ----- sv/life_generation_engine_core.sv -----
// ----------------------------------------------------------------------------
// Life generation engine core
// Grid of one-bit cells in a row-wide RAM; write, read and B3/S23 advance
// commands, each answered with the cell read, border liveness and count.
//
//   channel  dir  handshake              payload
//   in_ch    in   valid/ready            command, col, row, cell_in
//   out_ch   out  valid/ready            cell_out, border_alive, generation
//   cfg_*    in   APB write, pready = 1  grid_width @0x0, grid_height @0x4
//
// Write, read and unused commands end with a border scan of h rows. Advance
// steps the single cell unit one column a cycle over each row window, then
// writes each row back and scans the border. After reset a clearing pass
// zeroes the RAM; no item is taken meanwhile. A held result does not stop the
// next item being taken, but that item's result waits in ST_OUT.
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_generation_engine_core_assert.svh"

module life_generation_engine_core import lge_pkg::*; #(
  parameter int MAX_SIDE = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lge_in_if.sink                in_ch,
  lge_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int RW  = $clog2(MAX_SIDE);
  localparam int SWM = $clog2(MAX_SIDE + 1);
  localparam int SW  = (SWM > SIZE_REG_W) ? SWM : SIZE_REG_W;

  localparam logic [SW-1:0]       SIDE_MAX = SW'(MAX_SIDE);
  localparam logic [SW-1:0]       SIDE_TOP = SW'(MAX_SIDE - 1);
  localparam logic [MAX_SIDE-1:0] ONE_BIT  = {{(MAX_SIDE-1){1'b0}}, 1'b1};

  lge_state_t            state_r, state_nxt;
  logic [SIZE_REG_W-1:0] gw_r, gw_nxt, gh_r, gh_nxt;
  logic [GEN_W-1:0]      gen_r, gen_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SW-1:0]         clr_r, clr_nxt;

  lge_cmd_t              cmd_r, cmd_nxt;
  logic [COORD_W-1:0]    col_r, col_nxt, row_r, row_nxt;
  logic                  val_r, val_nxt;
  logic [MAX_SIDE-1:0]   wp_r, wp_nxt, wc_r, wc_nxt, wn_r, wn_nxt;
  logic [MAX_SIDE-1:0]   res_r, res_nxt;
  logic [SW-1:0]         rcnt_r, rcnt_nxt, fcnt_r, fcnt_nxt;
  logic [SW-1:0]         col_cnt_r, col_cnt_nxt, scnt_r, scnt_nxt;
  logic                  prime_r, prime_nxt;
  logic                  border_r, border_nxt;
  logic                  rd_bit_r, rd_bit_nxt;
  logic                  ocell_r, ocell_nxt, oborder_r, oborder_nxt;
  logic [GEN_W-1:0]      ogen_r, ogen_nxt;

  logic                  mem_we;
  logic [RW-1:0]         mem_waddr, mem_raddr;
  logic [MAX_SIDE-1:0]   mem_wdata, mem_rdata;

  logic [SW-1:0]         gw_ext, gh_ext, w_eff, h_eff, col_ext, row_ext, scan_row;
  logic                  in_area, cfg_wr, left_ok, right_ok, new_alive;
  logic [MAX_SIDE-1:0]   colmask, lastmask, cellmask, rdm;
  lge_nbhd_t             nbhd;

  lge_ram #(
    .WIDTH (MAX_SIDE),
    .DEPTH (MAX_SIDE)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lge_cell_unit u_cell (
    .nbhd       (nbhd),
    .next_alive (new_alive)
  );

  always_comb begin
    gw_ext   = SW'(gw_r);
    gh_ext   = SW'(gh_r);
    w_eff    = (gw_ext == '0) ? SW'(1) : ((gw_ext > SIDE_MAX) ? SIDE_MAX : gw_ext);
    h_eff    = (gh_ext == '0) ? SW'(1) : ((gh_ext > SIDE_MAX) ? SIDE_MAX : gh_ext);
    col_ext  = SW'(col_r);
    row_ext  = SW'(row_r);
    in_area  = (col_ext < w_eff) && (row_ext < h_eff);
    colmask  = {MAX_SIDE{1'b1}} >> (SIDE_MAX - w_eff);
    lastmask = ONE_BIT << (w_eff - SW'(1));
    cellmask = ONE_BIT << col_r;
    rdm      = mem_rdata & colmask;
    scan_row = scnt_r - SW'(1);
    left_ok  = (col_cnt_r != '0);
    right_ok = (col_cnt_r != SIDE_TOP);
    nbhd.nbr = {wp_r[MAX_SIDE-1] & left_ok, wp_r[0], wp_r[1] & right_ok,
                wc_r[MAX_SIDE-1] & left_ok,          wc_r[1] & right_ok,
                wn_r[MAX_SIDE-1] & left_ok, wn_r[0], wn_r[1] & right_ok};
    nbhd.alive = wc_r[0];
    cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_GRID_WIDTH) ? CFG_DATA_W'(gw_r)
                                                       : CFG_DATA_W'(gh_r);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cell_out     = ocell_r;
  assign out_ch.border_alive = oborder_r;
  assign out_ch.generation   = ogen_r;

  always_comb begin
    state_nxt     = state_r;
    gw_nxt        = gw_r;
    gh_nxt        = gh_r;
    gen_nxt       = gen_r;
    out_valid_nxt = out_valid_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    val_nxt       = val_r;
    wp_nxt        = wp_r;
    wc_nxt        = wc_r;
    wn_nxt        = wn_r;
    res_nxt       = res_r;
    rcnt_nxt      = rcnt_r;
    fcnt_nxt      = fcnt_r;
    col_cnt_nxt   = col_cnt_r;
    scnt_nxt      = scnt_r;
    prime_nxt     = prime_r;
    border_nxt    = border_r;
    rd_bit_nxt    = rd_bit_r;
    ocell_nxt     = ocell_r;
    oborder_nxt   = oborder_r;
    ogen_nxt      = ogen_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    in_ch.ready   = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr) begin
      if (cfg_paddr[2] == REG_GRID_WIDTH) begin
        gw_nxt = cfg_pwdata[SIZE_REG_W-1:0];
      end else begin
        gh_nxt = cfg_pwdata[SIZE_REG_W-1:0];
      end
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r[RW-1:0];
        clr_nxt   = clr_r + SW'(1);
        if (clr_r == SIDE_TOP) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        mem_raddr   = RW'(in_ch.row);
        if (in_ch.valid) begin
          cmd_nxt    = in_ch.command;
          col_nxt    = in_ch.col;
          row_nxt    = in_ch.row;
          val_nxt    = in_ch.cell_in;
          rd_bit_nxt = 1'b0;
          border_nxt = 1'b0;
          scnt_nxt   = '0;
          case (in_ch.command)
            CMD_ADVANCE: begin
              wp_nxt    = '0;
              wc_nxt    = '0;
              wn_nxt    = '0;
              rcnt_nxt  = '0;
              fcnt_nxt  = '0;
              prime_nxt = 1'b1;
              state_nxt = ST_FETCH;
            end
            CMD_WRITE, CMD_READ: state_nxt = ST_ACCESS;
            default:             state_nxt = ST_SCAN;
          endcase
        end
      end
      ST_ACCESS: begin
        if (cmd_r == CMD_WRITE) begin
          mem_we    = in_area;
          mem_waddr = RW'(row_r);
          mem_wdata = val_r ? (mem_rdata | cellmask) : (mem_rdata & ~cellmask);
        end else begin
          rd_bit_nxt = in_area && (|(mem_rdata & cellmask));
        end
        state_nxt = ST_SCAN;
      end
      ST_FETCH: begin
        mem_raddr = fcnt_r[RW-1:0];
        state_nxt = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        wp_nxt   = wc_r;
        wc_nxt   = wn_r;
        wn_nxt   = (fcnt_r < h_eff) ? rdm : '0;
        fcnt_nxt = fcnt_r + SW'(1);
        if (prime_r) begin
          prime_nxt = 1'b0;
          state_nxt = ST_FETCH;
        end else begin
          col_cnt_nxt = '0;
          state_nxt   = ST_CELL;
        end
      end
      ST_CELL: begin
        res_nxt     = {new_alive && (col_cnt_r < w_eff), res_r[MAX_SIDE-1:1]};
        wp_nxt      = {wp_r[0], wp_r[MAX_SIDE-1:1]};
        wc_nxt      = {wc_r[0], wc_r[MAX_SIDE-1:1]};
        wn_nxt      = {wn_r[0], wn_r[MAX_SIDE-1:1]};
        col_cnt_nxt = col_cnt_r + SW'(1);
        if (col_cnt_r == SIDE_TOP) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        mem_we    = 1'b1;
        mem_waddr = rcnt_r[RW-1:0];
        mem_wdata = (rcnt_r < h_eff) ? res_r : '0;
        rcnt_nxt  = rcnt_r + SW'(1);
        if (rcnt_r == SIDE_TOP) begin
          gen_nxt   = gen_r + GEN_W'(1);
          state_nxt = ST_SCAN;
        end else if ((rcnt_r + SW'(1)) < h_eff) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_SCAN: begin
        mem_raddr = scnt_r[RW-1:0];
        if (scnt_r != '0) begin
          if ((scan_row == '0) || (scan_row == (h_eff - SW'(1)))) begin
            border_nxt = border_r | (|rdm);
          end else begin
            border_nxt = border_r | rdm[0] | (|(rdm & lastmask));
          end
        end
        scnt_nxt = scnt_r + SW'(1);
        if (scnt_r == h_eff) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          ocell_nxt     = rd_bit_r;
          oborder_nxt   = border_r;
          ogen_nxt      = gen_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      gw_r        <= SIZE_RESET;
      gh_r        <= SIZE_RESET;
      gen_r       <= '0;
      out_valid_r <= 1'b0;
      clr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      gw_r        <= gw_nxt;
      gh_r        <= gh_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r       <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    val_r     <= val_nxt;
    wp_r      <= wp_nxt;
    wc_r      <= wc_nxt;
    wn_r      <= wn_nxt;
    res_r     <= res_nxt;
    rcnt_r    <= rcnt_nxt;
    fcnt_r    <= fcnt_nxt;
    col_cnt_r <= col_cnt_nxt;
    scnt_r    <= scnt_nxt;
    prime_r   <= prime_nxt;
    border_r  <= border_nxt;
    rd_bit_r  <= rd_bit_nxt;
    ocell_r   <= ocell_nxt;
    oborder_r <= oborder_nxt;
    ogen_r    <= ogen_nxt;
  end

  `LGE_ASSERT_IMPLY(a_no_write_in_cell, clk, rst_n, state_r == ST_CELL, !mem_we)
  `LGE_ASSERT_IMPLY(a_outside_write_dropped, clk, rst_n, (state_r == ST_ACCESS) && !in_area, !mem_we)
  `LGE_ASSERT_NEXT(a_gen_only_in_wb, clk, rst_n, state_r != ST_WB, $stable(gen_r))
  `LGE_ASSERT_NEXT(a_row_end_to_wb, clk, rst_n, (state_r == ST_CELL) && (col_cnt_r == SIDE_TOP), state_r == ST_WB)

endmodule

`default_nettype wire

// ----- sv/lge_ram.sv -----
// ----------------------------------------------------------------------------
// Life generation engine RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- sv/lge_cell_unit.sv -----
// ----------------------------------------------------------------------------
// Life generation engine cell unit
// Neighbor count and B3/S23 rule for one cell, reused for every cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lge_cell_unit import lge_pkg::*; (
  input  lge_nbhd_t nbhd,
  output logic      next_alive
);

  logic [NBR_CNT_W-1:0] count;

  always_comb begin
    count = '0;
    for (int i = 0; i < NBR_COUNT; i++) begin
      count = count + NBR_CNT_W'(nbhd.nbr[i]);
    end
    next_alive = (count == BIRTH_COUNT) || (nbhd.alive && (count == SURVIVE_COUNT));
  end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Life generation engine testbench
// Drives write, read, advance and unused commands into the engine. It resizes
// the grid through the register port, and between resizes it waits for the
// engine to drain. A scoreboard class keeps its own copy of the grid, the
// counter and the size registers. From that copy it works out each result and
// checks every returned item against the oldest expected one. Both channels
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench import lge_pkg::*; ();

  localparam int GRID_SIDE = 64;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic             cell_out;
    logic             border_alive;
    logic [GEN_W-1:0] generation;
  } life_result_t;

  class life_scoreboard;
    bit               cells [GRID_CELLS];
    bit [GEN_W-1:0]   gen_count;
    bit [SIZE_REG_W-1:0] width_reg;
    bit [SIZE_REG_W-1:0] height_reg;
    life_result_t     expected_q [$];
    int               mismatches;

    function new();
      foreach (cells[i]) cells[i] = 1'b0;
      gen_count  = '0;
      width_reg  = SIZE_RESET;
      height_reg = SIZE_RESET;
      mismatches = 0;
    endfunction

    function int side(bit [SIZE_REG_W-1:0] size_value);
      if (size_value == 0) return 1;
      if (size_value > GRID_SIDE) return GRID_SIDE;
      return int'(size_value);
    endfunction

    function bit live(int c, int r, int w, int h);
      if (c < 0 || r < 0 || c >= w || r >= h) return 1'b0;
      return cells[r * GRID_SIDE + c];
    endfunction

    function bit border(int w, int h);
      for (int i = 0; i < w; i++)
        if (live(i, 0, w, h) || live(i, h - 1, w, h)) return 1'b1;
      for (int i = 0; i < h; i++)
        if (live(0, i, w, h) || live(w - 1, i, w, h)) return 1'b1;
      return 1'b0;
    endfunction

    function void advance(int w, int h);
      bit fresh [GRID_CELLS];
      int count;
      foreach (fresh[i]) fresh[i] = 1'b0;
      for (int r = 0; r < h; r++) begin
        for (int c = 0; c < w; c++) begin
          count = 0;
          for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
              if (dr != 0 || dc != 0) count += live(c + dc, r + dr, w, h);
          if (live(c, r, w, h)) fresh[r * GRID_SIDE + c] = (count == 2 || count == 3);
          else fresh[r * GRID_SIDE + c] = (count == 3);
        end
      end
      cells = fresh;
      gen_count = gen_count + 1;
    endfunction

    function void set_register(logic idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_GRID_WIDTH) width_reg = data[SIZE_REG_W-1:0];
      else height_reg = data[SIZE_REG_W-1:0];
    endfunction

    function void note_command(lge_cmd_t cmd, logic [COORD_W-1:0] col,
                               logic [COORD_W-1:0] row, logic cell_in);
      int w;
      int h;
      bit rd;
      w = side(width_reg);
      h = side(height_reg);
      rd = 1'b0;
      case (cmd)
        CMD_WRITE: begin
          if (col < w && row < h) cells[row * GRID_SIDE + col] = cell_in;
        end
        CMD_READ: begin
          rd = live(col, row, w, h);
        end
        CMD_ADVANCE: begin
          advance(w, h);
        end
        default: begin
        end
      endcase
      expected_q.push_back({rd, border(w, h), gen_count});
    endfunction

    function void check_result(logic cell_out, logic border_alive,
                               logic [GEN_W-1:0] generation);
      life_result_t want;
      if (expected_q.size() == 0) begin
        $error("result item with no expected item waiting");
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (cell_out !== want.cell_out) begin
        $error("cell_out expected %0d actual %0d", want.cell_out, cell_out);
        mismatches++;
      end
      if (border_alive !== want.border_alive) begin
        $error("border_alive expected %0d actual %0d", want.border_alive, border_alive);
        mismatches++;
      end
      if (generation !== want.generation) begin
        $error("generation expected %0d actual %0d", want.generation, generation);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  lge_in_if  in_ch ();
  lge_out_if out_ch ();

  life_scoreboard board = new();
  bit hold_off_pending;
  int in_burst;
  int out_burst;

  life_generation_engine_core #(.MAX_SIDE(GRID_SIDE)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int draw_gap(ref int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 20);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  task automatic send_command(input lge_cmd_t cmd, input logic [COORD_W-1:0] col,
                              input logic [COORD_W-1:0] row, input logic cell_in);
    int gap;
    gap = draw_gap(in_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.command = cmd;
    in_ch.col     = col;
    in_ch.row     = row;
    in_ch.cell_in = cell_in;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    board.note_command(cmd, col, row, cell_in);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [SIZE_REG_W-1:0] value);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom;
    data[SIZE_REG_W-1:0] = value;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_pready) break;
    end
    board.set_register(idx, data);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic resize(input logic [SIZE_REG_W-1:0] w, input logic [SIZE_REG_W-1:0] h);
    drain();
    write_register(REG_GRID_WIDTH, w);
    write_register(REG_GRID_HEIGHT, h);
  endtask

  task automatic run_random(input logic [SIZE_REG_W-1:0] w_reg,
                            input logic [SIZE_REG_W-1:0] h_reg, input int count);
    int w;
    int h;
    int roll;
    int advance_pct;
    lge_cmd_t cmd;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    resize(w_reg, h_reg);
    w = board.side(w_reg);
    h = board.side(h_reg);
    advance_pct = (h > 16) ? 6 : 18;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) cmd = CMD_WRITE;
      else if (roll < 75) cmd = CMD_READ;
      else if (roll < 75 + advance_pct) cmd = CMD_ADVANCE;
      else cmd = CMD_NOP;
      if ($urandom_range(0, 99) < 85) begin
        col = COORD_W'($urandom_range(0, w - 1));
        row = COORD_W'($urandom_range(0, h - 1));
      end else begin
        col = COORD_W'($urandom_range(0, GRID_SIDE - 1));
        row = COORD_W'($urandom_range(0, GRID_SIDE - 1));
      end
      send_command(cmd, col, row, $urandom_range(0, 99) < 60);
    end
  endtask

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    out_burst = 0;
    forever begin
      stall = draw_gap(out_burst);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      forever begin
        @(posedge clk);
        if (out_ch.valid) break;
      end
      board.check_result(out_ch.cell_out, out_ch.border_alive, out_ch.generation);
    end
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_NOP;
    in_ch.col     = '0;
    in_ch.row     = '0;
    in_ch.cell_in = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    hold_off_pending = 1'b0;
    in_burst = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // full grid after reset: corners, a corner block and a blinker
    send_command(CMD_READ, 6'd0, 6'd0, 1'b0);
    send_command(CMD_WRITE, 6'd0, 6'd0, 1'b1);
    send_command(CMD_READ, 6'd0, 6'd0, 1'b0);
    send_command(CMD_WRITE, 6'd63, 6'd63, 1'b1);
    send_command(CMD_READ, 6'd63, 6'd63, 1'b1);
    send_command(CMD_WRITE, 6'd0, 6'd0, 1'b0);
    send_command(CMD_NOP, 6'd63, 6'd63, 1'b1);
    send_command(CMD_WRITE, 6'd62, 6'd63, 1'b1);
    send_command(CMD_WRITE, 6'd63, 6'd62, 1'b1);
    send_command(CMD_WRITE, 6'd62, 6'd62, 1'b1);
    send_command(CMD_WRITE, 6'd30, 6'd31, 1'b1);
    send_command(CMD_WRITE, 6'd31, 6'd31, 1'b1);
    send_command(CMD_WRITE, 6'd32, 6'd31, 1'b1);
    send_command(CMD_ADVANCE, 6'd0, 6'd0, 1'b0);
    send_command(CMD_READ, 6'd31, 6'd30, 1'b0);
    send_command(CMD_READ, 6'd30, 6'd31, 1'b0);
    send_command(CMD_ADVANCE, 6'd63, 6'd63, 1'b1);
    send_command(CMD_WRITE, 6'd63, 6'd63, 1'b0);
    send_command(CMD_WRITE, 6'd62, 6'd62, 1'b0);

    // zero size acts as one cell; writes outside are dropped
    resize(7'd0, 7'd0);
    send_command(CMD_WRITE, 6'd1, 6'd0, 1'b1);
    send_command(CMD_READ, 6'd1, 6'd0, 1'b0);
    send_command(CMD_WRITE, 6'd0, 6'd0, 1'b1);
    send_command(CMD_ADVANCE, 6'd0, 6'd0, 1'b0);

    // oversize acts as full grid; the shrunk advance cleared everything
    resize(7'd127, 7'd65);
    send_command(CMD_READ, 6'd31, 6'd31, 1'b0);
    send_command(CMD_READ, 6'd63, 6'd62, 1'b0);

    drain();
    hold_off_pending = 1'b1;
    run_random(7'd6, 7'd5, 18);
    run_random(7'd64, 7'd2, 12);
    run_random(7'd1, 7'd7, 10);
    run_random(7'd16, 7'd3, 12);
    run_random(7'd3, 7'd1, 10);
    run_random(7'd8, 7'd8, 20);
    run_random(7'd2, 7'd64, 10);
    run_random(7'd0, 7'd0, 6);
    run_random(7'd7, 7'd6, 17);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/lge_pkg.sv
sv/lge_if.sv
sv/lge_ram.sv
sv/lge_cell_unit.sv
sv/life_generation_engine_core.sv
sim/testbench.sv
